FILE: rtl/slcl_pkg.sv
// ============================================================================
// slcl_pkg
// Shared types and codes for the source connection limiter.
// ============================================================================
`default_nettype none

package slcl_pkg;

    // Event codes on the input channel
    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W            = 3;
    localparam logic [2:0]  REG_DEFAULT_LIMIT    = 3'd0;
    localparam logic [2:0]  REG_OVERRIDE_IP_A    = 3'd1;
    localparam logic [2:0]  REG_OVERRIDE_LIMIT_A = 3'd2;
    localparam logic [2:0]  REG_OVERRIDE_IP_B    = 3'd3;
    localparam logic [2:0]  REG_OVERRIDE_LIMIT_B = 3'd4;
    localparam logic [2:0]  REG_OVERRIDE_ENABLE  = 3'd5;

    // Register reset values and count ceiling
    localparam logic [31:0] RESET_DEFAULT_LIMIT = 32'd10000;
    localparam logic [31:0] COUNT_MAX           = 32'hFFFF_FFFF;

    // One way of a bucket row
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] count;
        logic        permit;
    } slot_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/slcl_ram.sv
// ============================================================================
// slcl_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module slcl_ram #(
    parameter int WIDTH = 264,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/source_connection_limiter_top.sv
// A result passes the accept registers and the lookup state to the output register.
// No event is taken in the lookup state, which does the read-modify-write of one
// bucket row in the table RAM (read in the accept cycle, write back in the next),
// or while a result waits. Reset: registers take their reset values, then a
// clearing pass zeroes every bucket row with s_ready low; config writes are taken.
// ============================================================================
// source_connection_limiter_top
// Per-source connection counting in a set-associative table, one RAM row per
// bucket holding all ways. BUCKETS must be a power of two.
// ============================================================================
`default_nettype none

module source_connection_limiter_top #(
    parameter int BUCKETS = 4096,
    parameter int WAYS    = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_source_ip,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_allowed,
    output logic [31:0]      m_conn_count,
    output logic [1:0]       m_status
);

    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W   = $bits(slcl_pkg::slot_t);
    localparam int ROW_W    = WAYS * SLOT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] default_limit_reg;
    logic [31:0] override_ip_a_reg;
    logic [31:0] override_limit_a_reg;
    logic [31:0] override_ip_b_reg;
    logic [31:0] override_limit_b_reg;
    logic [1:0]  override_enable_reg;

    assign cfg_ready = 1'b1;

    // Take register writes; ignore indexes past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_limit_reg    <= slcl_pkg::RESET_DEFAULT_LIMIT;
            override_ip_a_reg    <= '0;
            override_limit_a_reg <= '0;
            override_ip_b_reg    <= '0;
            override_limit_b_reg <= '0;
            override_enable_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                slcl_pkg::REG_DEFAULT_LIMIT:    default_limit_reg    <= cfg_data;
                slcl_pkg::REG_OVERRIDE_IP_A:    override_ip_a_reg    <= cfg_data;
                slcl_pkg::REG_OVERRIDE_LIMIT_A: override_limit_a_reg <= cfg_data;
                slcl_pkg::REG_OVERRIDE_IP_B:    override_ip_b_reg    <= cfg_data;
                slcl_pkg::REG_OVERRIDE_LIMIT_B: override_limit_b_reg <= cfg_data;
                slcl_pkg::REG_OVERRIDE_ENABLE:  override_enable_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    slcl_pkg::state_t      state_reg, state_next;
    logic [BUCKET_W-1:0]   clear_addr_reg, clear_addr_next;
    logic                  in_xfer;
    logic                  m_valid_reg;

    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= slcl_pkg::ST_CLEAR;
            clear_addr_reg <= '0;
        end else begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // Next state, clear sweep and input ready
    always_comb begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        s_ready         = 1'b0;
        case (state_reg)
            slcl_pkg::ST_CLEAR: begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == BUCKET_W'(BUCKETS - 1)) begin
                    state_next = slcl_pkg::ST_IDLE;
                end
            end
            slcl_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    state_next = slcl_pkg::ST_LOOK;
                end
            end
            slcl_pkg::ST_LOOK: begin
                state_next = slcl_pkg::ST_IDLE;
            end
            default: begin
                state_next = slcl_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Accept stage: bucket index, limit selection, capture of the event
    // ------------------------------------------------------------------
    logic [31:0]         hash_sum;
    logic [BUCKET_W-1:0] in_bucket;
    logic [31:0]         in_limit;
    logic [1:0]          act_reg;
    logic [31:0]         ip_reg;
    logic [31:0]         limit_reg;
    logic [BUCKET_W-1:0] bucket_reg;

    assign hash_sum  = s_source_ip + {16'd0, s_source_ip[31:16]};
    assign in_bucket = hash_sum[BUCKET_W-1:0];

    // Override a wins over override b
    always_comb begin
        if (override_enable_reg[0] && (s_source_ip == override_ip_a_reg)) begin
            in_limit = override_limit_a_reg;
        end else if (override_enable_reg[1] && (s_source_ip == override_ip_b_reg)) begin
            in_limit = override_limit_b_reg;
        end else begin
            in_limit = default_limit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            act_reg    <= s_action;
            ip_reg     <= s_source_ip;
            limit_reg  <= in_limit;
            bucket_reg <= in_bucket;
        end
    end

    // ------------------------------------------------------------------
    // Table RAM, one row of all ways per bucket
    // ------------------------------------------------------------------
    slcl_pkg::slot_t [WAYS-1:0] row_rd;
    slcl_pkg::slot_t [WAYS-1:0] row_wr;
    logic [ROW_W-1:0]           ram_rd_data;
    logic [ROW_W-1:0]           ram_wr_data;
    logic [BUCKET_W-1:0]        ram_wr_addr;
    logic                       ram_we;
    logic                       wr_ok;
    logic                       look;

    assign look   = (state_reg == slcl_pkg::ST_LOOK);
    assign row_rd = ram_rd_data;

    always_comb begin
        if (state_reg == slcl_pkg::ST_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = clear_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_we      = look && wr_ok;
            ram_wr_addr = bucket_reg;
            ram_wr_data = row_wr;
        end
    end

    slcl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (in_bucket),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Lookup stage: find hit and lowest free way
    // ------------------------------------------------------------------
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free;
    logic [WAY_W-1:0] free_way;

    // Descending scan so the lowest matching way wins
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_rd[w].valid) begin
                if (row_rd[w].addr == ip_reg) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end else begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // ------------------------------------------------------------------
    // Modify: update the chosen entry and build the result
    // ------------------------------------------------------------------
    slcl_pkg::slot_t  cur_slot;
    slcl_pkg::slot_t  upd_slot;
    logic [WAY_W-1:0] tgt_way;
    logic [1:0]       res_status;

    always_comb begin
        tgt_way = hit ? hit_way : free_way;
        if (hit) begin
            cur_slot = row_rd[hit_way];
        end else begin
            cur_slot.valid  = 1'b1;
            cur_slot.addr   = ip_reg;
            cur_slot.count  = '0;
            cur_slot.permit = 1'b1;
        end
        upd_slot   = cur_slot;
        wr_ok      = 1'b0;
        res_status = slcl_pkg::STAT_OK;
        case (act_reg)
            slcl_pkg::ACT_CLOSE: begin
                if (!hit) begin
                    res_status = slcl_pkg::STAT_UNKNOWN;
                end else begin
                    wr_ok = 1'b1;
                    if (cur_slot.count != '0) begin
                        upd_slot.count = cur_slot.count - 1'b1;
                    end
                    if (upd_slot.count < limit_reg) begin
                        upd_slot.permit = 1'b1;
                    end
                end
            end
            default: begin
                // open, query, and the unused code as query
                if (!hit && !free) begin
                    res_status = slcl_pkg::STAT_FULL;
                end else begin
                    wr_ok = 1'b1;
                    if (act_reg == slcl_pkg::ACT_OPEN) begin
                        if (cur_slot.count != slcl_pkg::COUNT_MAX) begin
                            upd_slot.count = cur_slot.count + 1'b1;
                        end
                        if (upd_slot.count >= limit_reg) begin
                            upd_slot.permit = 1'b0;
                        end
                    end
                end
            end
        endcase
        row_wr          = row_rd;
        row_wr[tgt_way] = upd_slot;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        m_allowed_reg;
    logic [31:0] m_conn_count_reg;
    logic [1:0]  m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (look) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result at the end of the lookup cycle
    always_ff @(posedge aclk) begin
        if (look) begin
            m_allowed_reg    <= wr_ok ? upd_slot.permit : 1'b0;
            m_conn_count_reg <= wr_ok ? upd_slot.count : '0;
            m_status_reg     <= res_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_allowed    = m_allowed_reg;
    assign m_conn_count = m_conn_count_reg;
    assign m_status     = m_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_look: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == slcl_pkg::ST_LOOK))
        else $error("accepted transfer did not enter lookup");

    a_look_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        look |-> !m_valid_reg)
        else $error("lookup with result register still occupied");

    a_look_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        look |=> m_valid_reg)
        else $error("lookup did not present a result");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != slcl_pkg::ST_IDLE))
        else $error("table write while idle");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg == slcl_pkg::STAT_OK ||
                         m_status_reg == slcl_pkg::STAT_FULL ||
                         m_status_reg == slcl_pkg::STAT_UNKNOWN))
        else $error("result status code out of range");

endmodule

`default_nettype wire

FILE: test/source_connection_limiter_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// source_connection_limiter_top_tb
// Drives open, close and query events into the connection limiter and checks
// every result against a scoreboard model of the bucket table or a directed value,
// across several register settings, with random sender bursts and receiver stalls.
// ============================================================================

module source_connection_limiter_top_tb;

    localparam int BUCKETS        = 4096;
    localparam int WAYS           = 4;
    localparam int SLOTS          = BUCKETS * WAYS;
    localparam int POOL_SIZE      = 18;
    localparam int CROWD_SIZE     = 6;
    localparam int PHASES         = 5;
    localparam int PHASE_EVENTS   = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 4 * BUCKETS + 2000;

    // Action code 3 is not defined and behaves as a query
    localparam logic [1:0] ACT_UNDEF  = 2'd3;
    // Register index past the end of the register list
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic        allowed;
        logic [31:0] conn_count;
        logic [1:0]  status;
    } conn_result_t;

    typedef enum logic {
        ROW_EVENT,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   act;
        logic [2:0]   idx;
        logic [31:0]  value;
        logic         known;
        conn_result_t want;
    } stim_row_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [31:0] s_source_ip;
    logic        m_valid;
    logic        m_ready;
    logic        m_allowed;
    logic [31:0] m_conn_count;
    logic [1:0]  m_status;

    // Scoreboard copy of the registers
    logic [31:0] lim_default;
    logic [31:0] ov_ip_a;
    logic [31:0] ov_limit_a;
    logic [31:0] ov_ip_b;
    logic [31:0] ov_limit_b;
    logic [1:0]  ov_enable;

    // Scoreboard copy of the table
    bit          tbl_used   [SLOTS];
    logic [31:0] tbl_ip     [SLOTS];
    logic [31:0] tbl_conns  [SLOTS];
    bit          tbl_permit [SLOTS];

    conn_result_t expected_results [$];
    stim_row_t    directed_rows [$];
    logic [31:0]  src_pool [POOL_SIZE];

    int mismatches;
    int quiet_cycles;
    int burst_left;
    int rx_left;
    int rx_phase;
    rx_mode_t rx_mode;

    source_connection_limiter_top #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_source_ip  (s_source_ip),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_allowed    (m_allowed),
        .m_conn_count (m_conn_count),
        .m_status     (m_status)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Apply one event to the table copy and return the result it should give
    function automatic conn_result_t track_event(logic [1:0] act, logic [31:0] ip);
        conn_result_t res;
        logic [31:0]  sum;
        logic [31:0]  lim;
        int           base;
        int           hit;
        int           spare;
        int           s;
        res   = '0;
        sum   = ip + {16'h0000, ip[31:16]};
        base  = (sum % BUCKETS) * WAYS;
        hit   = -1;
        spare = -1;
        for (int w = 0; w < WAYS; w++) begin
            s = base + w;
            if (tbl_used[s]) begin
                if (hit < 0 && tbl_ip[s] == ip)
                    hit = s;
            end else if (spare < 0) begin
                spare = s;
            end
        end

        // Override a takes priority when both match
        lim = lim_default;
        if (ov_enable[1] && ip == ov_ip_b)
            lim = ov_limit_b;
        if (ov_enable[0] && ip == ov_ip_a)
            lim = ov_limit_a;

        if (act == slcl_pkg::ACT_CLOSE) begin
            if (hit < 0) begin
                res.status = slcl_pkg::STAT_UNKNOWN;
                return res;
            end
            s = hit;
            if (tbl_conns[s] != 32'd0)
                tbl_conns[s] = tbl_conns[s] - 32'd1;
            if (tbl_conns[s] < lim)
                tbl_permit[s] = 1'b1;
        end else begin
            if (hit < 0) begin
                if (spare < 0) begin
                    res.status = slcl_pkg::STAT_FULL;
                    return res;
                end
                s             = spare;
                tbl_used[s]   = 1'b1;
                tbl_ip[s]     = ip;
                tbl_conns[s]  = 32'd0;
                tbl_permit[s] = 1'b1;
            end else begin
                s = hit;
            end
            // Count saturation needs 2^32 opens and is out of reach here
            if (act == slcl_pkg::ACT_OPEN) begin
                if (tbl_conns[s] != slcl_pkg::COUNT_MAX)
                    tbl_conns[s] = tbl_conns[s] + 32'd1;
                if (tbl_conns[s] >= lim)
                    tbl_permit[s] = 1'b0;
            end
        end
        res.allowed    = tbl_permit[s];
        res.conn_count = tbl_conns[s];
        res.status     = slcl_pkg::STAT_OK;
        return res;
    endfunction

    function automatic void track_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            slcl_pkg::REG_DEFAULT_LIMIT:    lim_default = data;
            slcl_pkg::REG_OVERRIDE_IP_A:    ov_ip_a     = data;
            slcl_pkg::REG_OVERRIDE_LIMIT_A: ov_limit_a  = data;
            slcl_pkg::REG_OVERRIDE_IP_B:    ov_ip_b     = data;
            slcl_pkg::REG_OVERRIDE_LIMIT_B: ov_limit_b  = data;
            slcl_pkg::REG_OVERRIDE_ENABLE:  ov_enable   = data[1:0];
            default: ;
        endcase
    endfunction

    // Limits biased toward values that event counts actually cross
    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(1, 4));
            4:       return 32'($urandom_range(5, 16));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_source();
        if ($urandom_range(0, 99) < 88)
            return src_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    task automatic add_event(logic [1:0] act, logic [31:0] ip);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_EVENT;
        row.act   = act;
        row.value = ip;
        directed_rows.push_back(row);
    endtask

    task automatic add_event_known(logic [1:0] act, logic [31:0] ip, logic allowed,
                                   logic [31:0] count, logic [1:0] status);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_EVENT;
        row.act   = act;
        row.value = ip;
        row.known = 1'b1;
        row.want  = {allowed, count, status};
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(logic [2:0] idx, logic [31:0] data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = data;
        directed_rows.push_back(row);
    endtask

    // Send one event, with bursts of back-to-back transfers and random gaps between
    task automatic send_event(logic [1:0] act, logic [31:0] ip, logic known,
                              conn_result_t want);
        conn_result_t pred;
        int           gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_action    <= act;
        s_source_ip <= ip;
        do @(posedge aclk); while (!s_ready);
        pred = track_event(act, ip);
        expected_results.push_back(known ? want : pred);
    endtask

    // Hold off until every result is back and the pipeline is empty
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        track_reg(idx, data);
    endtask

    task automatic end_reg_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver stall pattern: stretches of always ready, random stalls, or one in three
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(32, 200);
        end else begin
            rx_left = rx_left - 1;
        end
        rx_phase = (rx_phase == 2) ? 0 : rx_phase + 1;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
            default:   m_ready <= (rx_phase == 0);
        endcase
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        conn_result_t got;
        conn_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_allowed, m_conn_count, m_status};
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: allowed=%0d count=%0d status=%0d",
                             got.allowed, got.conn_count, got.status);
            end else begin
                want = expected_results.pop_front();
                if (got.allowed !== want.allowed || got.conn_count !== want.conn_count ||
                    got.status !== want.status) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected allowed=%0d count=%0d status=%0d, %s",
                                 want.allowed, want.conn_count, want.status,
                                 $sformatf("got allowed=%0d count=%0d status=%0d",
                                           got.allowed, got.conn_count, got.status));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        int        bucket;
        int        hi;
        int        lo;
        int        open_pct;
        int        pick;
        logic [1:0] act;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_action     = '0;
        s_source_ip  = '0;
        m_ready      = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        rx_left      = 0;
        rx_phase     = 0;
        rx_mode      = RX_OPEN;

        lim_default = slcl_pkg::RESET_DEFAULT_LIMIT;
        ov_ip_a     = '0;
        ov_limit_a  = '0;
        ov_ip_b     = '0;
        ov_limit_b  = '0;
        ov_enable   = '0;

        // Source pool: random addresses plus a crowd that shares one bucket
        bucket = $urandom_range(0, BUCKETS - 1);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < CROWD_SIZE) begin
                hi = $urandom_range(0, 65535);
                lo = ((bucket - hi) & (BUCKETS - 1)) +
                     BUCKETS * $urandom_range(0, 65536 / BUCKETS - 1);
                src_pool[i] = {hi[15:0], lo[15:0]};
            end else begin
                src_pool[i] = $urandom();
            end
        end

        // Directed table: reset limit first
        add_event_known(slcl_pkg::ACT_OPEN,  32'h0000_0000, 1'b1, 32'd1, slcl_pkg::STAT_OK);
        add_event_known(slcl_pkg::ACT_CLOSE, 32'h0000_0000, 1'b1, 32'd0, slcl_pkg::STAT_OK);
        add_event_known(slcl_pkg::ACT_CLOSE, 32'h0000_0000, 1'b1, 32'd0, slcl_pkg::STAT_OK);
        add_event_known(slcl_pkg::ACT_CLOSE, 32'hFFFF_FFFF, 1'b0, 32'd0,
                        slcl_pkg::STAT_UNKNOWN);
        add_event_known(slcl_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1, 32'd0, slcl_pkg::STAT_OK);
        add_event_known(ACT_UNDEF, 32'hFFFF_FFFF, 1'b1, 32'd0, slcl_pkg::STAT_OK);
        // Both overrides on the same address, a must win
        add_reg(slcl_pkg::REG_DEFAULT_LIMIT,    32'd2);
        add_reg(slcl_pkg::REG_OVERRIDE_IP_A,    32'h0A00_0001);
        add_reg(slcl_pkg::REG_OVERRIDE_LIMIT_A, 32'd0);
        add_reg(slcl_pkg::REG_OVERRIDE_IP_B,    32'h0A00_0001);
        add_reg(slcl_pkg::REG_OVERRIDE_LIMIT_B, 32'd5);
        add_reg(slcl_pkg::REG_OVERRIDE_ENABLE,  32'd3);
        add_event_known(slcl_pkg::ACT_OPEN, 32'h0A00_0001, 1'b0, 32'd1, slcl_pkg::STAT_OK);
        add_event(slcl_pkg::ACT_OPEN,  32'h0A00_0001);
        add_event(slcl_pkg::ACT_CLOSE, 32'h0A00_0001);
        // Cross the default limit up and back down
        add_event(slcl_pkg::ACT_OPEN,  32'hC0A8_0001);
        add_event(slcl_pkg::ACT_OPEN,  32'hC0A8_0001);
        add_event(slcl_pkg::ACT_CLOSE, 32'hC0A8_0001);
        // Fill one bucket, then miss on it
        add_event(slcl_pkg::ACT_OPEN, 32'h0000_0123);
        add_event(slcl_pkg::ACT_OPEN, 32'h0000_1123);
        add_event(slcl_pkg::ACT_OPEN, 32'h0000_2123);
        add_event(slcl_pkg::ACT_OPEN, 32'h0000_3123);
        add_event_known(slcl_pkg::ACT_OPEN,  32'h0000_4123, 1'b0, 32'd0,
                        slcl_pkg::STAT_FULL);
        add_event_known(slcl_pkg::ACT_QUERY, 32'h0000_4123, 1'b0, 32'd0,
                        slcl_pkg::STAT_FULL);
        add_event_known(slcl_pkg::ACT_CLOSE, 32'h0000_4123, 1'b0, 32'd0,
                        slcl_pkg::STAT_UNKNOWN);
        // Only override b, widest default
        add_reg(slcl_pkg::REG_OVERRIDE_ENABLE, 32'd2);
        add_reg(slcl_pkg::REG_DEFAULT_LIMIT,   32'hFFFF_FFFF);
        add_event(slcl_pkg::ACT_OPEN,  32'h0A00_0001);
        add_event(slcl_pkg::ACT_CLOSE, 32'h0A00_0001);
        add_event(slcl_pkg::ACT_OPEN,  32'hC0A8_0001);
        // Zero default, no overrides, stray index ignored
        add_reg(slcl_pkg::REG_DEFAULT_LIMIT,   32'd0);
        add_reg(slcl_pkg::REG_OVERRIDE_ENABLE, 32'd0);
        add_reg(REG_UNUSED,                    32'hFFFF_FFFF);
        add_event_known(slcl_pkg::ACT_QUERY, 32'h7FFF_FFFF, 1'b1, 32'd0, slcl_pkg::STAT_OK);
        add_event(slcl_pkg::ACT_OPEN,  32'h7FFF_FFFF);
        add_event(slcl_pkg::ACT_CLOSE, 32'h7FFF_FFFF);

        // Release reset
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG) begin
                if (cfg_valid !== 1'b1)
                    drain();
                write_reg(row.idx, row.value);
            end else begin
                if (cfg_valid === 1'b1)
                    end_reg_writes();
                send_event(row.act, row.value, row.known, row.want);
            end
        end

        // Random phases, each with fresh register settings
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(slcl_pkg::REG_DEFAULT_LIMIT,    pick_limit());
            write_reg(slcl_pkg::REG_OVERRIDE_IP_A,    pick_source());
            write_reg(slcl_pkg::REG_OVERRIDE_LIMIT_A, pick_limit());
            write_reg(slcl_pkg::REG_OVERRIDE_IP_B,    pick_source());
            write_reg(slcl_pkg::REG_OVERRIDE_LIMIT_B, pick_limit());
            write_reg(slcl_pkg::REG_OVERRIDE_ENABLE,  32'($urandom_range(0, 3)));
            write_reg(REG_UNUSED,                     $urandom());
            end_reg_writes();
            open_pct = $urandom_range(30, 60);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < open_pct)
                    act = slcl_pkg::ACT_OPEN;
                else if (pick < open_pct + 30)
                    act = slcl_pkg::ACT_CLOSE;
                else if (pick < 96)
                    act = slcl_pkg::ACT_QUERY;
                else
                    act = ACT_UNDEF;
                send_event(act, pick_source(), 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
